// ===== src/ffha_pkg.sv =====
package ffha_pkg;

    localparam int ARENA_BYTES  = 1048576;
    localparam int HEADER_BYTES = 24;
    localparam int MAX_BLOCKS   = 1024;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W  = 21;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_NULL = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    typedef struct packed {
        logic [1:0]       operation;
        logic [OFF_W-1:0] request_size;
        logic [OFF_W-1:0] address;
        logic             address_present;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFF_W-1:0] result_address;
        logic [OFF_W-1:0] copy_bytes;
        logic             relocated;
    } rsp_t;

    // table entry: header offset, payload bytes, free mark
    typedef struct packed {
        logic [19:0] start;
        logic [19:0] bytes;
        logic        is_free;
    } ent_t;

    // table pointer update
    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC,
        PTR_HIT,
        PTR_CNT
    } ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // working entry update
    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_TAKE,    // load read data
        CUR_ALLOC,   // shrink to request and mark used
        CUR_FREE,
        CUR_USED,
        CUR_ABSORB,  // grow over the entry just read
        CUR_MERGE    // entry just read grows over cur
    } cur_op_t;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_PREV,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_CUR,
        WR_RD,
        WR_TAIL
    } wr_sel_t;

    typedef struct packed {
        logic       rd_free;
        logic       fits;
        logic       split_ok;
        logic       addr_match;
        logic       at_end;
        logic       ptr_zero;
        logic       next_exists;
        logic       above_slot;
        logic       size_zero;
        logic       present;
        logic [1:0] operation;
        logic       old_fits;
    } stat_t;

endpackage

// ===== src/ffha_datapath.sv =====
module ffha_datapath
    import ffha_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  req_t             req,
    input  logic             mem_rd,
    input  rd_sel_t          rd_sel,
    input  logic             mem_wr,
    input  wr_sel_t          wr_sel,
    input  ptr_op_t          ptr_op,
    input  cnt_op_t          cnt_op,
    input  cur_op_t          cur_op,
    input  logic             save_hit,
    input  logic             save_old,
    input  logic             save_new,
    input  logic             fit_mode,  // 1 selects the new block address
    output stat_t            stat,
    output logic [OFF_W-1:0] new_addr,
    output logic [19:0]      old_bytes
);
    ent_t mem [MAX_BLOCKS];
    ent_t rd_reg;
    ent_t cur_reg, cur_next;
    req_t req_reg;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] hit_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] rd_addr;
    ent_t wr_data;
    logic [19:0] old_reg;
    logic [OFF_W-1:0] na_reg;
    logic [21:0] size_hdr;
    logic [CNT_W-1:0] ptr_plus;
    logic [CNT_W-1:0] hit_plus;
    logic init_reg;

    assign size_hdr = {1'b0, req_reg.request_size} + 22'(HEADER_BYTES);
    assign ptr_plus = {1'b0, ptr_reg} + CNT_W'(1);
    assign hit_plus = {1'b0, hit_reg} + CNT_W'(1);

    always_comb
    begin
        case (rd_sel)
            RD_PREV: rd_addr = ptr_reg - IDX_W'(1);
            RD_NEXT: rd_addr = ptr_reg + IDX_W'(1);
            default: rd_addr = ptr_reg;
        endcase
    end

    always_comb
    begin
        wr_data = cur_reg;
        case (wr_sel)
            WR_RD:   wr_data = rd_reg;
            WR_TAIL:
            begin
                wr_data.start   = 20'(21'(cur_reg.start) + 21'(HEADER_BYTES)
                                  + req_reg.request_size);
                wr_data.bytes   = 20'(21'(cur_reg.bytes) - size_hdr[20:0]);
                wr_data.is_free = 1'b1;
            end
            default: wr_data = cur_reg;
        endcase
    end

    // entry 0 is written on the first edge after reset
    always_ff @(posedge clk)
    begin
        if (mem_rd)
            rd_reg <= mem[rd_addr];
        if (init_reg)
            mem[0] <= '{start: 20'd0, bytes: 20'(ARENA_BYTES - HEADER_BYTES),
                       is_free: 1'b1};
        else if (mem_wr)
            mem[ptr_reg] <= wr_data;
    end

    always_comb
    begin
        cur_next = cur_reg;
        case (cur_op)
            CUR_TAKE: cur_next = rd_reg;
            CUR_ALLOC:
            begin
                cur_next.bytes   = req_reg.request_size[19:0];
                cur_next.is_free = 1'b0;
            end
            CUR_FREE: cur_next.is_free = 1'b1;
            CUR_ABSORB: cur_next.bytes = 20'(21'(cur_reg.bytes) + 21'(HEADER_BYTES)
                                         + 21'(rd_reg.bytes));
            CUR_MERGE:
            begin
                cur_next       = rd_reg;
                cur_next.bytes = 20'(21'(rd_reg.bytes) + 21'(HEADER_BYTES)
                                 + 21'(cur_reg.bytes));
            end
            CUR_USED: cur_next.is_free = 1'b0;
            default: cur_next = cur_reg;
        endcase
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        case (ptr_op)
            PTR_ZERO: ptr_next = '0;
            PTR_INC:  ptr_next = ptr_reg + IDX_W'(1);
            PTR_DEC:  ptr_next = ptr_reg - IDX_W'(1);
            PTR_HIT:  ptr_next = hit_reg;
            PTR_CNT:  ptr_next = cnt_reg[IDX_W-1:0];
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        case (cnt_op)
            CNT_INC: cnt_next = cnt_reg + CNT_W'(1);
            CNT_DEC: cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= CNT_W'(1);
            ptr_reg  <= '0;
            init_reg <= 1'b1;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            ptr_reg  <= ptr_next;
            init_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            req_reg <= req;
        cur_reg <= cur_next;
        if (save_hit)
            hit_reg <= ptr_reg;
        if (save_old)
            old_reg <= cur_reg.bytes;
        if (save_new)
            na_reg <= 21'(cur_reg.start) + 21'(HEADER_BYTES);
    end

    assign stat.rd_free     = rd_reg.is_free;
    assign stat.fits        = rd_reg.is_free
                              && ({1'b0, rd_reg.bytes} >= req_reg.request_size);
    assign stat.split_ok    = ({2'b0, cur_reg.bytes} > size_hdr)
                              && (cnt_reg < CNT_W'(MAX_BLOCKS));
    assign stat.addr_match  = (21'(rd_reg.start) + 21'(HEADER_BYTES)) == req_reg.address;
    assign stat.at_end      = ptr_plus >= cnt_reg;
    assign stat.ptr_zero    = ptr_reg == '0;
    assign stat.next_exists = ptr_plus < cnt_reg;
    assign stat.above_slot  = {1'b0, ptr_reg} > hit_plus;
    assign stat.size_zero   = req_reg.request_size == '0;
    assign stat.present     = req_reg.address_present;
    assign stat.operation   = req_reg.operation;
    assign stat.old_fits    = {1'b0, cur_reg.bytes} >= req_reg.request_size;
    assign new_addr  = fit_mode ? na_reg : req_reg.address;
    assign old_bytes = old_reg;
endmodule

// ===== src/ffha_ctrl.sv =====
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             load,
    output logic             mem_rd,
    output rd_sel_t          rd_sel,
    output logic             mem_wr,
    output wr_sel_t          wr_sel,
    output ptr_op_t          ptr_op,
    output cnt_op_t          cnt_op,
    output cur_op_t          cur_op,
    output logic             save_hit,
    output logic             save_old,
    output logic             save_new,
    output logic             fit_mode,
    input  stat_t            stat,
    input  logic [OFF_W-1:0] new_addr,
    input  logic [19:0]      old_bytes,
    output logic             done,
    output rsp_t             rsp
);
    typedef enum logic [21:0] {
        S_IDLE   = 22'd1,
        S_DISP   = 22'd2,
        S_FRD    = 22'd4,       // find: read issued
        S_FCHK   = 22'd8,
        S_FREE   = 22'd16,      // cur holds block at ptr
        S_NRD    = 22'd32,      // read next
        S_NCHK   = 22'd64,
        S_RMRD   = 22'd128,     // remove entry: read ptr+1
        S_RMWR   = 22'd256,
        S_RMEND  = 22'd512,
        S_PRD    = 22'd1024,    // read prev
        S_PCHK   = 22'd2048,
        S_FWB    = 22'd4096,
        S_POSTF  = 22'd8192,    // write back freed cur, merged if a neighbour was free
        S_ARD    = 22'd16384,   // alloc walk
        S_ACHK   = 22'd32768,
        S_AWR    = 22'd65536,
        S_SUPRD  = 22'd131072,  // shift up: read ptr-1
        S_SUPWR  = 22'd262144,
        S_SPLIT  = 22'd524288,
        S_AFIN   = 22'd1048576,
        S_DONE   = 22'd2097152
    } state_t;

    // what the current walk is for
    localparam logic [1:0] PH_FREE = 2'd0;   // free op
    localparam logic [1:0] PH_RA   = 2'd1;   // realloc lookup
    localparam logic [1:0] PH_RF   = 2'd2;   // realloc relocation free
    localparam logic [1:0] PH_RZ   = 2'd3;   // realloc to zero

    state_t state_reg, state_next;
    logic [1:0] ph_reg, ph_next;
    logic       ra_reg, ra_next;     // alloc is part of realloc
    logic       rm_prev_reg, rm_prev_next; // removal for prev merge
    rsp_t       rsp_reg, rsp_next;
    logic       done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ph_reg      <= PH_FREE;
            ra_reg      <= 1'b0;
            rm_prev_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ph_reg      <= ph_next;
            ra_reg      <= ra_next;
            rm_prev_reg <= rm_prev_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    function automatic rsp_t mk(logic [1:0] s, logic [OFF_W-1:0] a,
                                logic [OFF_W-1:0] c, logic m);
        rsp_t r;
        r.status = s; r.result_address = a; r.copy_bytes = c; r.relocated = m;
        return r;
    endfunction

    always_comb
    begin
        state_next   = state_reg;
        ph_next      = ph_reg;
        ra_next      = ra_reg;
        rm_prev_next = rm_prev_reg;
        rsp_next     = rsp_reg;
        done_next    = 1'b0;
        load = 1'b0; mem_rd = 1'b0; rd_sel = RD_PTR; mem_wr = 1'b0; wr_sel = WR_CUR;
        ptr_op = PTR_HOLD; cnt_op = CNT_HOLD; cur_op = CUR_HOLD;
        save_hit = 1'b0; save_old = 1'b0; save_new = 1'b0; fit_mode = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    load       = 1'b1;
                    ptr_op     = PTR_ZERO;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                ra_next      = 1'b0;
                rm_prev_next = 1'b0;
                if (stat.operation == OP_ALLOC
                    || (stat.operation == OP_REALLOC && !stat.present))
                begin
                    if (stat.size_zero)
                    begin
                        rsp_next = mk(ST_NULL, '0, '0, 1'b0); state_next = S_DONE;
                    end
                    else
                    begin
                        mem_rd = 1'b1; state_next = S_ACHK;
                    end
                end
                else if (stat.operation == OP_FREE)
                begin
                    if (!stat.present)
                    begin
                        rsp_next = mk(ST_NULL, '0, '0, 1'b0); state_next = S_DONE;
                    end
                    else
                    begin
                        ph_next = PH_FREE; mem_rd = 1'b1; state_next = S_FCHK;
                    end
                end
                else if (stat.operation == OP_REALLOC)
                begin
                    ph_next = PH_RA; mem_rd = 1'b1; state_next = S_FCHK;
                end
                else
                begin
                    rsp_next = mk(ST_NULL, '0, '0, 1'b0); state_next = S_DONE;
                end
            end
            S_FRD:
            begin
                mem_rd = 1'b1; state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (stat.addr_match)
                begin
                    if (stat.rd_free)
                    begin
                        rsp_next = mk(ST_BAD, '0, '0, 1'b0); state_next = S_DONE;
                    end
                    else
                    begin
                        cur_op = CUR_TAKE; save_hit = 1'b1;
                        state_next = S_FREE;
                    end
                end
                else if (stat.at_end)
                begin
                    rsp_next = mk(ST_BAD, '0, '0, 1'b0); state_next = S_DONE;
                end
                else
                begin
                    ptr_op = PTR_INC; state_next = S_FRD;
                end
            end
            S_FREE:
            begin
                // cur holds the found used block, ptr is its index
                if (ph_reg == PH_RA)
                begin
                    if (stat.size_zero)
                    begin
                        ph_next = PH_RZ; cur_op = CUR_FREE; state_next = S_NRD;
                    end
                    else if (stat.old_fits)
                    begin
                        fit_mode   = 1'b0;
                        rsp_next   = mk(ST_OK, new_addr, '0, 1'b0);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        save_old = 1'b1; ra_next = 1'b1; ptr_op = PTR_ZERO;
                        state_next = S_ARD;
                    end
                end
                else
                begin
                    cur_op = CUR_FREE; state_next = S_NRD;
                end
            end
            S_NRD:
            begin
                if (stat.next_exists)
                begin
                    mem_rd = 1'b1; rd_sel = RD_NEXT; state_next = S_NCHK;
                end
                else
                    state_next = S_PRD;
            end
            S_NCHK:
            begin
                if (stat.rd_free)
                begin
                    cur_op = CUR_ABSORB; rm_prev_next = 1'b0;
                    ptr_op = PTR_INC; state_next = S_RMRD;
                end
                else
                    state_next = S_PRD;
            end
            S_RMRD:
            begin
                // remove entry at ptr by moving later entries down
                if (stat.next_exists)
                begin
                    mem_rd = 1'b1; rd_sel = RD_NEXT; state_next = S_RMWR;
                end
                else
                begin
                    cnt_op = CNT_DEC; state_next = S_RMEND;
                end
            end
            S_RMWR:
            begin
                mem_wr = 1'b1; wr_sel = WR_RD; ptr_op = PTR_INC; state_next = S_RMRD;
            end
            S_RMEND:
            begin
                ptr_op = PTR_HIT;
                if (rm_prev_reg)
                    state_next = S_FWB;
                else
                    state_next = S_PRD;
            end
            S_PRD:
            begin
                if (!stat.ptr_zero)
                begin
                    mem_rd = 1'b1; rd_sel = RD_PREV; state_next = S_PCHK;
                end
                else
                    state_next = S_FWB;
            end
            S_PCHK:
            begin
                if (stat.rd_free)
                begin
                    // merged block lives at hit-1; drop entry hit
                    cur_op = CUR_MERGE; rm_prev_next = 1'b1;
                    state_next = S_RMRD;
                end
                else
                    state_next = S_FWB;
            end
            S_FWB:
            begin
                if (rm_prev_reg)
                    ptr_op = PTR_DEC;
                state_next = S_POSTF;
            end
            S_POSTF:
            begin
                mem_wr = 1'b1; wr_sel = WR_CUR; rm_prev_next = 1'b0;
                fit_mode = ph_reg == PH_RF;
                state_next = S_DONE;
                case (ph_reg)
                    PH_FREE: rsp_next = mk(ST_OK, new_addr, '0, 1'b0);
                    PH_RZ:   rsp_next = mk(ST_NULL, '0, '0, 1'b0);
                    default: rsp_next = mk(ST_OK, new_addr, OFF_W'(old_bytes), 1'b1);
                endcase
            end
            S_ARD:
            begin
                mem_rd = 1'b1; state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (stat.fits)
                begin
                    cur_op = CUR_TAKE; save_hit = 1'b1; state_next = S_AWR;
                end
                else if (stat.at_end)
                begin
                    rsp_next = mk(ST_OOM, '0, '0, 1'b0); state_next = S_DONE;
                end
                else
                begin
                    ptr_op = PTR_INC; state_next = S_ARD;
                end
            end
            S_AWR:
            begin
                save_new = 1'b1;
                if (stat.split_ok)
                begin
                    ptr_op = PTR_CNT; state_next = S_SUPRD;
                end
                else
                begin
                    cur_op = CUR_USED; state_next = S_AFIN;
                end
            end
            S_SUPRD:
            begin
                // open a slot at hit+1 by moving entries up
                if (stat.above_slot)
                begin
                    mem_rd = 1'b1; rd_sel = RD_PREV; state_next = S_SUPWR;
                end
                else
                    state_next = S_SPLIT;
            end
            S_SUPWR:
            begin
                mem_wr = 1'b1; wr_sel = WR_RD; ptr_op = PTR_DEC; state_next = S_SUPRD;
            end
            S_SPLIT:
            begin
                mem_wr = 1'b1; wr_sel = WR_TAIL; cnt_op = CNT_INC;
                cur_op = CUR_ALLOC; ptr_op = PTR_HIT; state_next = S_AFIN;
            end
            S_AFIN:
            begin
                mem_wr = 1'b1; wr_sel = WR_CUR;
                if (ra_reg)
                begin
                    // look the old block up again, the split may have moved it
                    ph_next = PH_RF; ptr_op = PTR_ZERO; state_next = S_FRD;
                end
                else
                begin
                    rsp_next = mk(ST_OK, new_addr, '0, 1'b0); state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ===== src/first_fit_heap_allocator_unit.sv =====
// first-fit heap allocator over a 1 MiB arena with up to 1024 blocks in an address-ordered
// table. start is taken when busy is low; one result beat follows on done for one cycle and
// the receiver cannot stall it. the table is a single-port memory with registered reads, so
// the walk reads and then checks each entry visited, and splits and merges move the table
// entries one by one, each by a read and then a write.
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);
    logic       load, mem_rd, mem_wr, save_hit, save_old, save_new, fit_mode;
    rd_sel_t    rd_sel;
    wr_sel_t    wr_sel;
    cnt_op_t    cnt_op;
    ptr_op_t    ptr_op;
    cur_op_t    cur_op;
    stat_t      stat;
    logic [OFF_W-1:0] new_addr;
    logic [19:0] old_bytes;

    ffha_datapath u_dp (
        .clk, .rst_n, .load, .req, .mem_rd, .rd_sel, .mem_wr, .wr_sel,
        .ptr_op, .cnt_op, .cur_op, .save_hit, .save_old, .save_new, .fit_mode,
        .stat, .new_addr, .old_bytes
    );

    ffha_ctrl u_ctrl (
        .clk, .rst_n, .start, .busy, .load, .mem_rd, .rd_sel, .mem_wr, .wr_sel,
        .ptr_op, .cnt_op, .cur_op, .save_hit, .save_old, .save_new, .fit_mode,
        .stat, .new_addr, .old_bytes, .done, .rsp
    );
endmodule

// ===== verif/first_fit_heap_allocator_unit_test.sv =====
module first_fit_heap_allocator_unit_test;
    import ffha_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 200000;
    localparam int RANDOM_ITEMS    = 270;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    first_fit_heap_allocator_unit dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .req  (req),
        .busy (busy),
        .done (done),
        .rsp  (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // shadow copy of the block table
    int unsigned hp_start[MAX_BLOCKS];
    int unsigned hp_bytes[MAX_BLOCKS];
    bit          hp_free[MAX_BLOCKS];
    int unsigned hp_count;

    rsp_t pending_rsp[$];
    int   error_count;
    int   beats_in;
    int   beats_out;
    int   idle_cycles;
    int   relocations;
    int   stat_seen[4];
    bit   no_idle;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at beat %0d: %s got 0x%0h expected 0x%0h",
                 beats_out, what, got, want);
        error_count++;
    endtask

    function automatic void heap_reset();
        hp_start[0] = 0;
        hp_bytes[0] = ARENA_BYTES - HEADER_BYTES;
        hp_free[0]  = 1'b1;
        hp_count    = 1;
    endfunction

    function automatic void heap_remove(int unsigned k);
        for (int unsigned j = k; j + 1 < hp_count; j++)
        begin
            hp_start[j] = hp_start[j + 1];
            hp_bytes[j] = hp_bytes[j + 1];
            hp_free[j]  = hp_free[j + 1];
        end
        hp_count--;
    endfunction

    function automatic int heap_find_used(int unsigned addr);
        for (int unsigned i = 0; i < hp_count; i++)
            if (hp_start[i] + HEADER_BYTES == addr)
                return hp_free[i] ? -1 : int'(i);
        return -1;
    endfunction

    function automatic bit heap_take(int unsigned size, output int unsigned addr);
        addr = 0;
        for (int unsigned i = 0; i < hp_count; i++)
        begin
            if (hp_free[i] && hp_bytes[i] >= size)
            begin
                if (hp_bytes[i] > size + HEADER_BYTES && hp_count < MAX_BLOCKS)
                begin
                    for (int unsigned j = hp_count; j > i + 1; j--)
                    begin
                        hp_start[j] = hp_start[j - 1];
                        hp_bytes[j] = hp_bytes[j - 1];
                        hp_free[j]  = hp_free[j - 1];
                    end
                    hp_start[i + 1] = hp_start[i] + HEADER_BYTES + size;
                    hp_bytes[i + 1] = hp_bytes[i] - size - HEADER_BYTES;
                    hp_free[i + 1]  = 1'b1;
                    hp_count++;
                    hp_bytes[i] = size;
                end
                hp_free[i] = 1'b0;
                addr = hp_start[i] + HEADER_BYTES;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void heap_release(int unsigned idx);
        hp_free[idx] = 1'b1;
        if (idx + 1 < hp_count && hp_free[idx + 1])
        begin
            hp_bytes[idx] += HEADER_BYTES + hp_bytes[idx + 1];
            heap_remove(idx + 1);
        end
        if (idx > 0 && hp_free[idx - 1])
        begin
            hp_bytes[idx - 1] += HEADER_BYTES + hp_bytes[idx];
            heap_remove(idx);
        end
    endfunction

    function automatic rsp_t heap_apply(req_t r);
        rsp_t        o;
        int          idx;
        int unsigned na;
        int unsigned old_bytes;
        int unsigned size;
        int unsigned addr;
        o = '0;
        o.status = ST_NULL;
        size = 32'(r.request_size);
        addr = 32'(r.address);
        if (r.operation == OP_ALLOC || (r.operation == OP_REALLOC && !r.address_present))
        begin
            if (size != 0)
            begin
                if (heap_take(size, na))
                begin
                    o.status = ST_OK;
                    o.result_address = OFF_W'(na);
                end
                else
                    o.status = ST_OOM;
            end
        end
        else if (r.operation == OP_FREE)
        begin
            if (r.address_present)
            begin
                idx = heap_find_used(addr);
                if (idx < 0)
                    o.status = ST_BAD;
                else
                begin
                    heap_release(idx);
                    o.status = ST_OK;
                    o.result_address = OFF_W'(addr);
                end
            end
        end
        else if (r.operation == OP_REALLOC)
        begin
            idx = heap_find_used(addr);
            if (idx < 0)
                o.status = ST_BAD;
            else if (size == 0)
                heap_release(idx);
            else if (hp_bytes[idx] >= size)
            begin
                o.status = ST_OK;
                o.result_address = OFF_W'(addr);
            end
            else
            begin
                old_bytes = hp_bytes[idx];
                if (heap_take(size, na))
                begin
                    heap_release(heap_find_used(addr));
                    o.status = ST_OK;
                    o.result_address = OFF_W'(na);
                    o.copy_bytes = OFF_W'(old_bytes);
                    o.relocated = 1'b1;
                end
                else
                    o.status = ST_OOM;
            end
        end
        return o;
    endfunction

    // result checking at each rising edge
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("unexpected result beat, status %0d", rsp.status);
                error_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.result_address !== want.result_address)
                    report_mismatch("result_address", rsp.result_address,
                                    want.result_address);
                if (rsp.copy_bytes !== want.copy_bytes)
                    report_mismatch("copy_bytes", rsp.copy_bytes, want.copy_bytes);
                if (rsp.relocated !== want.relocated)
                    report_mismatch("relocated", rsp.relocated, want.relocated);
                stat_seen[want.status]++;
                if (want.relocated)
                    relocations++;
            end
            beats_out++;
        end
    end

    // watchdog: cycles without any beat in either direction
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("watchdog expired, %0d results outstanding", pending_rsp.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // drive one request beat and predict its result when it is taken
    task automatic send_request(input req_t r, input bit has_want, input rsp_t want);
        rsp_t model;
        while (!no_idle && $urandom_range(99) < 26)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        model = heap_apply(r);
        if (has_want && model !== want)
        begin
            $display("directed row %0d disagrees with predictor", beats_in);
            error_count++;
        end
        pending_rsp.push_back(model);
        beats_in++;
        @(negedge clk);
    endtask

    function automatic req_t make_req(logic [1:0] op, int unsigned size, int unsigned addr,
                                      bit present);
        req_t r;
        r.operation       = op;
        r.request_size    = OFF_W'(size);
        r.address         = OFF_W'(addr);
        r.address_present = present;
        return r;
    endfunction

    function automatic rsp_t make_rsp(logic [1:0] st, int unsigned addr);
        rsp_t o;
        o = '0;
        o.status = st;
        o.result_address = OFF_W'(addr);
        return o;
    endfunction

    typedef struct {
        req_t r;
        bit   has_want;
        rsp_t want;
    } dir_row_t;

    int unsigned live_addr[$];

    initial
    begin
        dir_row_t    rows[$];
        req_t        r;
        int unsigned pick;
        int unsigned sz;
        int          kind;
        rsp_t        none;

        start       = 1'b0;
        req         = '0;
        rst_n       = 1'b0;
        error_count = 0;
        beats_in    = 0;
        beats_out   = 0;
        relocations = 0;
        no_idle     = 1'b0;
        none        = '0;
        heap_reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        rows.push_back('{make_req(OP_ALLOC, 0, 0, 0), 1, make_rsp(ST_NULL, 0)});
        rows.push_back('{make_req(OP_ALLOC, 1, 0, 0), 1, make_rsp(ST_OK, 24)});
        rows.push_back('{make_req(OP_FREE, 0, 0, 0), 1, make_rsp(ST_NULL, 0)});
        rows.push_back('{make_req(OP_FREE, 0, 24, 1), 1, make_rsp(ST_OK, 24)});
        rows.push_back('{make_req(OP_FREE, 0, 24, 1), 1, make_rsp(ST_BAD, 0)});
        rows.push_back('{make_req(OP_ALLOC, 1048576, 0, 0), 1, make_rsp(ST_OOM, 0)});
        rows.push_back('{make_req(OP_ALLOC, 21'h1FFFFF, 0, 0), 1, make_rsp(ST_OOM, 0)});
        rows.push_back('{make_req(OP_ALLOC, 1048552, 0, 0), 1, make_rsp(ST_OK, 24)});
        rows.push_back('{make_req(OP_ALLOC, 1, 0, 0), 1, make_rsp(ST_OOM, 0)});
        rows.push_back('{make_req(OP_FREE, 0, 24, 1), 1, make_rsp(ST_OK, 24)});
        rows.push_back('{make_req(OP_ALLOC, 100, 0, 0), 0, none});
        rows.push_back('{make_req(OP_ALLOC, 200, 0, 0), 0, none});
        rows.push_back('{make_req(OP_REALLOC, 50, 24, 1), 0, none});
        rows.push_back('{make_req(OP_REALLOC, 500, 24, 1), 0, none});
        rows.push_back('{make_req(OP_REALLOC, 64, 0, 0), 0, none});
        rows.push_back('{make_req(OP_REALLOC, 10, 21'h1FFFFF, 1), 1, make_rsp(ST_BAD, 0)});
        rows.push_back('{make_req(OP_REALLOC, 0, 21'h1FFFFF, 1), 1, make_rsp(ST_BAD, 0)});
        rows.push_back('{make_req(OP_REALLOC, 0, 148, 1), 0, none});
        rows.push_back('{make_req(OP_REALLOC, 21'h100000, 372, 1), 0, none});
        rows.push_back('{make_req(2'd3, 21'h1FFFFF, 21'h1FFFFF, 1), 1,
                         make_rsp(ST_NULL, 0)});
        rows.push_back('{make_req(OP_FREE, 0, 0, 1), 1, make_rsp(ST_BAD, 0)});
        foreach (rows[i])
            send_request(rows[i].r, rows[i].has_want, rows[i].want);

        // track live blocks from the shadow table for the random part
        for (int unsigned i = 0; i < hp_count; i++)
            if (!hp_free[i])
                live_addr.push_back(hp_start[i] + HEADER_BYTES);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n >= 100 && n < 160);
            if (n == 200)
            begin
                // hold off until the block has drained
                start <= 1'b0;
                wait (pending_rsp.size() == 0);
                @(negedge clk);
            end
            kind = $urandom_range(99);
            sz = ($urandom_range(19) == 0) ? $urandom_range(21'h1FFFFF)
                                           : $urandom_range(1, 4096);
            if (kind < 40 || live_addr.size() == 0)
                r = make_req(OP_ALLOC, ($urandom_range(29) == 0) ? 0 : sz, $urandom,
                             1'($urandom));
            else if (kind < 70)
            begin
                pick = $urandom_range(live_addr.size() - 1);
                r = make_req(OP_FREE, $urandom, live_addr[pick], 1);
            end
            else if (kind < 88)
            begin
                pick = $urandom_range(live_addr.size() - 1);
                r = make_req(OP_REALLOC, ($urandom_range(9) == 0) ? 0 : sz,
                             live_addr[pick], 1);
            end
            else
                r = make_req(2'($urandom_range(3)), $urandom, $urandom, 1'($urandom));
            send_request(r, 1'b0, none);
            live_addr.delete();
            for (int unsigned i = 0; i < hp_count; i++)
                if (!hp_free[i])
                    live_addr.push_back(hp_start[i] + HEADER_BYTES);
        end

        start <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (50) @(posedge clk);
        $display("%0d requests, %0d results: ok %0d, oom %0d, null %0d, bad %0d",
                 beats_in, beats_out, stat_seen[ST_OK], stat_seen[ST_OOM],
                 stat_seen[ST_NULL], stat_seen[ST_BAD]);
        $display("%0d relocating reallocates, %0d blocks in table at end",
                 relocations, hp_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
